### hw/rtl/twam_pkg.sv
// ----------------------------------------------------------------------------
// twam_pkg
// Shared constants, types and helpers for the touch wheel angle block.
// ----------------------------------------------------------------------------
package twam_pkg;

  // Breakpoint table geometry
  localparam int unsigned MaxPoints = 16;
  localparam int unsigned PtIdxW    = $clog2(MaxPoints);
  localparam int unsigned PtCntW    = $clog2(MaxPoints + 1);

  // Field widths
  localparam int unsigned PadW      = 16;
  localparam int unsigned AngW      = 9;
  localparam int unsigned MinW      = 6;
  localparam int unsigned PtsW      = 5;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned EntryW    = 2 * AngW;

  // Shared divider sizing
  localparam int unsigned DivNumW   = 24;
  localparam int unsigned DivDshW   = 26;
  localparam int unsigned DivQuoW   = 18;
  localparam int unsigned DivCntW   = 5;
  localparam int unsigned SecSteps  = 7;
  localparam int unsigned IntSteps  = 18;

  // Angle constants
  localparam logic [7:0]  SectorSpan = 8'd120;
  localparam logic [7:0]  SectorB    = 8'd120;
  localparam logic [7:0]  SectorC    = 8'd240;
  localparam logic [9:0]  FullTurn   = 10'd360;
  localparam logic [9:0]  TwoTurns   = 10'd720;
  localparam logic [AngW-1:0] AngMax = 9'd360;

  // Minute = angle / 6, exact for angles up to 360
  localparam logic [7:0]  MinuteMul   = 8'd171;
  localparam int unsigned MinuteShift = 10;

  typedef enum logic {
    ACT_MEASURE = 1'b0,
    ACT_LOAD    = 1'b1
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ANGLE_OFFSET    = 2'd0,
    CFG_TOUCH_THRESHOLD = 2'd1,
    CFG_POINTS_IN_USE   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] num;
    logic [DivDshW-1:0] dsh;
    logic [DivCntW-1:0] steps;
  } div_cmd_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DivQuoW-1:0] quo;
  } div_rsp_t;

  function automatic logic [MinW-1:0] minute_of(input logic [AngW-1:0] ang);
    logic [16:0] prod;
    prod = 17'(ang) * 17'(MinuteMul);
    return prod[MinuteShift +: MinW];
  endfunction

endpackage

### hw/rtl/twam_in_if.sv
// ----------------------------------------------------------------------------
// twam_in_if
// Request channel: measure or breakpoint load, valid/ready handshake.
// ----------------------------------------------------------------------------
interface twam_in_if import twam_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            action;
  logic [PadW-1:0] proximity;
  logic [PadW-1:0] pad_a;
  logic [PadW-1:0] pad_b;
  logic [PadW-1:0] pad_c;
  logic [3:0]      point_index;
  logic [AngW-1:0] point_measured;
  logic [AngW-1:0] point_real;

  modport source (
    output valid, action, proximity, pad_a, pad_b, pad_c,
           point_index, point_measured, point_real,
    input  ready
  );

  modport sink (
    input  valid, action, proximity, pad_a, pad_b, pad_c,
           point_index, point_measured, point_real,
    output ready
  );
endinterface

### hw/rtl/twam_out_if.sv
// ----------------------------------------------------------------------------
// twam_out_if
// Result channel: valid flag, press flag, angle and minute.
// ----------------------------------------------------------------------------
interface twam_out_if import twam_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            valid_res;
  logic            pressed;
  logic [AngW-1:0] angle;
  logic [MinW-1:0] minute;

  modport source (
    output valid, valid_res, pressed, angle, minute,
    input  ready
  );

  modport sink (
    input  valid, valid_res, pressed, angle, minute,
    output ready
  );
endinterface

### hw/rtl/touch_wheel_angle_to_minute.sv
// ----------------------------------------------------------------------------
// touch_wheel_angle_to_minute
// Three-pad touch wheel to corrected angle and minute, via a shared divider.
// ----------------------------------------------------------------------------
// Load request: written to the table from idle, no result; the next request may follow at once.
// Measure request: with all pads at zero, straight from prep through wrap to the
//   result register; else the divider runs for the sector position when both
//   differences are nonzero, the search passes up to 14 breakpoints, and the
//   divider runs for the interpolation term unless the segment has zero width.
//   The next request is taken in the cycle after the load.
// Reset clears the sequencer and output valid; offset, threshold and points in
//   use become 0, 0 and 2; breakpoint table contents stay undefined until loaded.
module touch_wheel_angle_to_minute import twam_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  twam_in_if.sink             in_i,
  twam_out_if.source          out_o
);

  // Sequencer: one request at a time, one-hot states
  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_PREP   = 15'b000000000000010,
    S_SSTART = 15'b000000000000100,
    S_SDIV   = 15'b000000000001000,
    S_WRAP   = 15'b000000000010000,
    S_SRD    = 15'b000000000100000,
    S_SCHK   = 15'b000000001000000,
    S_LORD   = 15'b000000010000000,
    S_HIRD   = 15'b000000100000000,
    S_HICAP  = 15'b000001000000000,
    S_MUL    = 15'b000010000000000,
    S_ISTART = 15'b000100000000000,
    S_IDIV   = 15'b001000000000000,
    S_SCALE  = 15'b010000000000000,
    S_FIN    = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [AngW-1:0] offset_q;
  logic [PadW-1:0] thresh_q;
  logic [PtsW-1:0] points_q;

  // Request and working registers
  logic [PadW-1:0]   pad_a_q, pad_b_q, pad_c_q;
  logic              press_q;
  logic              valid_q;
  logic [PadW-1:0]   ap_q, aq_q;
  logic [7:0]        base_q;
  logic [6:0]        pos_q;
  logic [AngW-1:0]   ang_a_q;
  logic [PtIdxW-1:0] i_q;
  logic [AngW-1:0]   lo_meas_q, lo_real_q, hi_meas_q, hi_real_q;
  logic signed [19:0] prod_q;
  logic signed [9:0]  den_q;
  logic               neg_q;
  logic [DivQuoW-1:0] scl_q;
  logic [AngW-1:0]    ang_q;

  // Output register
  logic            out_valid_q;
  logic            out_res_q;
  logic            out_press_q;
  logic [AngW-1:0] out_ang_q;
  logic [MinW-1:0] out_min_q;

  logic acc;
  logic out_load;

  // Table and divider hookup
  logic              ram_we;
  logic [PtIdxW-1:0] ram_raddr;
  logic [EntryW-1:0] ram_rdata;
  logic [AngW-1:0]   rd_meas, rd_real;
  div_cmd_t          div_cmd;
  div_rsp_t          div_rsp;

  function automatic logic [PadW-1:0] absdiff(input logic [PadW-1:0] x,
                                              input logic [PadW-1:0] y);
    return (x >= y) ? (x - y) : (y - x);
  endfunction

  assign acc      = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign out_load = (state_q == S_FIN) && (!out_valid_q || out_o.ready);

  // ---------------------------------------------------------------------------
  // Breakpoint table: {measured, real} per slot
  // ---------------------------------------------------------------------------
  assign ram_we = acc && (in_i.action == ACT_LOAD) && (32'(in_i.point_index) < MaxPoints);

  twam_ram #(
    .Width (EntryW),
    .Depth (MaxPoints)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (PtIdxW'(in_i.point_index)),
    .wdata_i ({in_i.point_measured, in_i.point_real}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_meas = ram_rdata[EntryW-1:AngW];
  assign rd_real = ram_rdata[AngW-1:0];

  // Read the upper breakpoint of the segment while searching and fetching it
  always_comb begin
    case (state_q)
      S_SRD, S_HIRD: ram_raddr = i_q + 1'b1;
      default:       ram_raddr = i_q;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sector choice: drop the weakest pad, the two strongest pick the sector
  // ---------------------------------------------------------------------------
  logic            za, zb, zc, multi_zero;
  logic            sec1, sec2;
  logic [PadW-1:0] ap_c, aq_c;
  logic [7:0]      base_c;

  always_comb begin
    za         = (pad_a_q == '0);
    zb         = (pad_b_q == '0);
    zc         = (pad_c_q == '0);
    multi_zero = (za && zb) || (za && zc) || (zb && zc);
    sec1       = (pad_a_q > pad_c_q) && (pad_b_q > pad_c_q);
    sec2       = (pad_b_q > pad_a_q) && (pad_c_q > pad_a_q);
    if (sec1) begin
      ap_c   = absdiff(pad_a_q, pad_c_q);
      aq_c   = absdiff(pad_b_q, pad_c_q);
      base_c = '0;
    end else if (sec2) begin
      ap_c   = absdiff(pad_b_q, pad_a_q);
      aq_c   = absdiff(pad_c_q, pad_a_q);
      base_c = SectorB;
    end else begin
      // Pads a and c tied below b land here with equal magnitudes: mid-sector
      ap_c   = absdiff(pad_c_q, pad_b_q);
      aq_c   = absdiff(pad_a_q, pad_b_q);
      base_c = SectorC;
    end
  end

  // Sector position numerator and divisor: round-half-away of 120*q/(p+q)
  logic [PadW:0]      sum_c;
  logic [DivNumW-1:0] num_c;

  assign sum_c = {1'b0, ap_q} + {1'b0, aq_q};
  assign num_c = (DivNumW'(aq_q) << 8) - (DivNumW'(aq_q) << 4) + DivNumW'(sum_c);

  // ---------------------------------------------------------------------------
  // Wrap, search bound, interpolation terms
  // ---------------------------------------------------------------------------
  logic [9:0]        raw_c;
  logic [AngW-1:0]   wrap_c;
  logic [PtCntW-1:0] n_c;
  logic              more_c;

  always_comb begin
    raw_c = 10'(offset_q) + 10'(base_q) + 10'(pos_q);
    if (raw_c >= TwoTurns) begin
      wrap_c = AngW'(raw_c - TwoTurns);
    end else if (raw_c >= FullTurn) begin
      wrap_c = AngW'(raw_c - FullTurn);
    end else begin
      wrap_c = AngW'(raw_c);
    end
  end

  always_comb begin
    if (points_q < PtsW'(2)) begin
      n_c = PtCntW'(2);
    end else if (32'(points_q) > MaxPoints) begin
      n_c = PtCntW'(MaxPoints);
    end else begin
      n_c = PtCntW'(points_q);
    end
  end

  assign more_c = (32'(i_q) + 2) < 32'(n_c);

  logic signed [9:0]  dr_c, da_c, den_c;
  logic [19:0]        prod_mag;
  logic [9:0]         den_mag;
  logic signed [19:0] scl_s, corr_c;
  logic [AngW-1:0]    sat_c;

  always_comb begin
    dr_c     = $signed({1'b0, hi_real_q}) - $signed({1'b0, lo_real_q});
    da_c     = $signed({1'b0, ang_a_q}) - $signed({1'b0, lo_meas_q});
    den_c    = $signed({1'b0, hi_meas_q}) - $signed({1'b0, lo_meas_q});
    prod_mag = prod_q[19] ? 20'(-prod_q) : 20'(prod_q);
    den_mag  = den_q[9] ? 10'(-den_q) : 10'(den_q);
    // Interpolation term truncates toward zero: divide magnitudes, then sign
    scl_s    = neg_q ? -$signed({2'b00, scl_q}) : $signed({2'b00, scl_q});
    corr_c   = $signed({11'd0, lo_real_q}) + scl_s;
    if (corr_c < 0) begin
      sat_c = '0;
    end else if (corr_c > $signed(20'(AngMax))) begin
      sat_c = AngMax;
    end else begin
      sat_c = corr_c[AngW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Shared divider
  // ---------------------------------------------------------------------------
  always_comb begin
    div_cmd = '0;
    case (state_q)
      S_SSTART: begin
        div_cmd.start = 1'b1;
        div_cmd.num   = num_c;
        div_cmd.dsh   = DivDshW'({sum_c, 1'b0, 6'd0});
        div_cmd.steps = DivCntW'(SecSteps);
      end
      S_ISTART: begin
        div_cmd.start = (den_q != '0);
        div_cmd.num   = DivNumW'(prod_mag[17:0]);
        div_cmd.dsh   = {den_mag[8:0], 17'd0};
        div_cmd.steps = DivCntW'(IntSteps);
      end
      default: ;
    endcase
  end

  twam_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (div_cmd),
    .rsp_o  (div_rsp)
  );

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (acc && (in_i.action == ACT_MEASURE)) state_d = S_PREP;
      end
      S_PREP: begin
        if (!multi_zero && (ap_c != '0) && (aq_c != '0)) state_d = S_SSTART;
        else                                              state_d = S_WRAP;
      end
      S_SSTART: state_d = S_SDIV;
      S_SDIV: begin
        if (div_rsp.done) state_d = S_WRAP;
      end
      S_WRAP: begin
        state_d = valid_q ? S_SRD : S_FIN;
      end
      S_SRD: begin
        state_d = more_c ? S_SCHK : S_LORD;
      end
      S_SCHK: begin
        state_d = (ang_a_q > rd_meas) ? S_SRD : S_LORD;
      end
      S_LORD:   state_d = S_HIRD;
      S_HIRD:   state_d = S_HICAP;
      S_HICAP:  state_d = S_MUL;
      S_MUL:    state_d = S_ISTART;
      S_ISTART: begin
        state_d = (den_q == '0) ? S_SCALE : S_IDIV;
      end
      S_IDIV: begin
        if (div_rsp.done) state_d = S_SCALE;
      end
      S_SCALE:  state_d = S_FIN;
      S_FIN: begin
        if (out_load) state_d = S_IDLE;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      offset_q    <= '0;
      thresh_q    <= '0;
      points_q    <= PtsW'(2);
    end else begin
      state_q <= state_d;
      // Hold the result until taken; a fresh load wins over a take
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_ANGLE_OFFSET:    offset_q <= cfg_data_i[AngW-1:0];
          CFG_TOUCH_THRESHOLD: thresh_q <= cfg_data_i[PadW-1:0];
          CFG_POINTS_IN_USE:   points_q <= cfg_data_i[PtsW-1:0];
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          pad_a_q <= in_i.pad_a;
          pad_b_q <= in_i.pad_b;
          pad_c_q <= in_i.pad_c;
          press_q <= (in_i.proximity > thresh_q);
        end
      end
      S_PREP: begin
        valid_q <= !(za && zb && zc);
        ap_q    <= ap_c;
        aq_q    <= aq_c;
        if (multi_zero) begin
          // Single live pad: sit exactly on it
          pos_q      <= '0;
          base_q     <= !za ? 8'd0 : (!zb ? SectorB : SectorC);
        end else begin
          base_q     <= base_c;
          // First difference zero puts us at the sector end, second at its start
          pos_q      <= (ap_c == '0) ? 7'(SectorSpan) : 7'd0;
        end
      end
      S_SDIV: begin
        if (div_rsp.done) pos_q <= div_rsp.quo[6:0];
      end
      S_WRAP: begin
        ang_a_q <= wrap_c;
        i_q     <= '0;
      end
      S_SCHK: begin
        if (ang_a_q > rd_meas) i_q <= i_q + 1'b1;
      end
      S_HIRD: begin
        lo_meas_q <= rd_meas;
        lo_real_q <= rd_real;
      end
      S_HICAP: begin
        hi_meas_q <= rd_meas;
        hi_real_q <= rd_real;
      end
      S_MUL: begin
        prod_q <= dr_c * da_c;
        den_q  <= den_c;
      end
      S_ISTART: begin
        neg_q <= prod_q[19] ^ den_q[9];
        if (den_q == '0) scl_q <= '0;
      end
      S_IDIV: begin
        if (div_rsp.done) scl_q <= div_rsp.quo;
      end
      S_SCALE: begin
        ang_q <= sat_c;
      end
      default: ;
    endcase

    if (out_load) begin
      out_res_q   <= valid_q;
      out_press_q <= press_q;
      out_ang_q   <= valid_q ? ang_q : '0;
      out_min_q   <= valid_q ? minute_of(ang_q) : '0;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.valid_res = out_res_q;
  assign out_o.pressed   = out_press_q;
  assign out_o.angle     = out_ang_q;
  assign out_o.minute    = out_min_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_cmd.start |-> !div_rsp.busy)
    else $error("divider restarted while still busy");

  a_seg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_HICAP) |-> ((32'(i_q) + 2) <= 32'(n_c)))
    else $error("breakpoint segment beyond points in use");

  a_ang_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) && valid_q |-> (ang_q <= AngMax))
    else $error("corrected angle escaped saturation");

  a_measure_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (in_i.action == ACT_MEASURE) |=> (state_q == S_PREP))
    else $error("accepted measure request not started");

endmodule

### hw/rtl/twam_ram.sv
// ----------------------------------------------------------------------------
// twam_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module twam_ram #(
  parameter  int unsigned Width = 18,
  parameter  int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/twam_div.sv
// ----------------------------------------------------------------------------
// twam_div
// Shared restoring divider: one quotient bit per cycle, pre-aligned divisor.
// ----------------------------------------------------------------------------
module twam_div import twam_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_cmd_t cmd_i,
  output div_rsp_t rsp_o
);

  logic               busy_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DivNumW-1:0] rem_q;
  logic [DivDshW-1:0] dsh_q;
  logic [DivQuoW-1:0] quo_q;

  logic               ge;
  logic [DivDshW-1:0] diff;

  assign ge   = {{(DivDshW - DivNumW){1'b0}}, rem_q} >= dsh_q;
  assign diff = {{(DivDshW - DivNumW){1'b0}}, rem_q} - dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= cmd_i.steps;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      rem_q <= cmd_i.num;
      dsh_q <= cmd_i.dsh;
      quo_q <= '0;
    end else if (busy_q && (cnt_q != '0)) begin
      if (ge) begin
        rem_q <= diff[DivNumW-1:0];
      end
      quo_q <= {quo_q[DivQuoW-2:0], ge};
      dsh_q <= dsh_q >> 1;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = busy_q && (cnt_q == '0);
  assign rsp_o.quo  = quo_q;

  // Remainder must stay below twice the aligned divisor, else a quotient bit is lost
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && (cnt_q != '0) |-> ({3'b000, rem_q} < {dsh_q, 1'b0}))
    else $error("divider remainder overflowed its aligned divisor");

  a_start_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |=> busy_q && (cnt_q == $past(cmd_i.steps)))
    else $error("divider did not take up a started request");

  a_done_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.done && !cmd_i.start |=> !busy_q)
    else $error("divider stayed busy after its last step");

endmodule

### sim/twam_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twam_checker
// Watches the request, result and register ports of the touch wheel block,
// works out the expected reading for every measure request and compares each
// result with the oldest expected reading.
// ----------------------------------------------------------------------------
module twam_checker import twam_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  twam_in_if                  req_i,
  twam_out_if                 res_i,
  output int unsigned         fail_count_o,
  output int unsigned         outstanding_o
);

  localparam int SectorStep = 120;
  localparam int Turn       = 360;
  localparam int DegPerMin  = 6;
  localparam int MaxReports = 10;

  typedef struct packed {
    logic            valid_res;
    logic            pressed;
    logic [AngW-1:0] angle;
    logic [MinW-1:0] minute;
  } reading_t;

  logic [AngW-1:0] bp_measured [MaxPoints];
  logic [AngW-1:0] bp_true     [MaxPoints];
  logic [AngW-1:0] offset_q;
  logic [PadW-1:0] threshold_q;
  logic [PtsW-1:0] points_q;
  reading_t        pending_readings [$];
  int unsigned     mismatches;

  initial begin
    for (int k = 0; k < MaxPoints; k++) begin
      bp_measured[k] = '0;
      bp_true[k]     = '0;
    end
  end

  // Rounded position inside a sector from the two pad differences.
  function automatic int in_sector(input int p, input int q);
    int unsigned ap, aq, span;
    if (p == 0) return SectorStep;
    if (q == 0) return 0;
    ap   = (p < 0) ? -p : p;
    aq   = (q < 0) ? -q : q;
    span = ap + aq;
    if (span == 0) return 0;
    return int'((240 * aq + span) / (2 * span));
  endfunction

  // Piecewise-linear warp over the breakpoint table.
  function automatic int warp_angle(input int a);
    int n, i, lm, hm, lr, hr, den, term;
    n = int'(points_q);
    if (n < 2) n = 2;
    if (n > MaxPoints) n = MaxPoints;
    i = 0;
    while (i + 2 < n && a > int'(bp_measured[i + 1])) i++;
    lm   = int'(bp_measured[i]);
    hm   = int'(bp_measured[i + 1]);
    lr   = int'(bp_true[i]);
    hr   = int'(bp_true[i + 1]);
    den  = hm - lm;
    term = 0;
    if (den != 0) term = ((hr - lr) * (a - lm)) / den;
    return lr + term;
  endfunction

  function automatic reading_t predict_reading(input logic [PadW-1:0] prox,
                                               input logic [PadW-1:0] pa,
                                               input logic [PadW-1:0] pb,
                                               input logic [PadW-1:0] pc);
    int a, b, c, raw, ang, zeros;
    reading_t r;
    a = int'(pa);
    b = int'(pb);
    c = int'(pc);
    r = '0;
    r.pressed = (prox > threshold_q);
    raw   = int'(offset_q);
    zeros = int'(a == 0) + int'(b == 0) + int'(c == 0);
    if (zeros > 1) begin
      if (a != 0) raw += 0;
      else if (b != 0) raw += SectorStep;
      else if (c != 0) raw += 2 * SectorStep;
      else return r;
    end else if (a > c && b > c) begin
      raw += in_sector(a - c, b - c);
    end else if (b > a && c > a) begin
      raw += in_sector(b - a, c - a) + SectorStep;
    end else begin
      raw += in_sector(c - b, a - b) + 2 * SectorStep;
    end
    ang = warp_angle(raw % Turn);
    if (ang < 0) ang = 0;
    if (ang > Turn) ang = Turn;
    r.valid_res = 1'b1;
    r.angle     = AngW'(ang);
    r.minute    = MinW'(ang / DegPerMin);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    reading_t got;
    reading_t want;
    if (!rst_ni) begin
      offset_q    = '0;
      threshold_q = '0;
      points_q    = PtsW'(2);
      pending_readings.delete();
      mismatches  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ANGLE_OFFSET:    offset_q    = cfg_data_i[AngW-1:0];
          CFG_TOUCH_THRESHOLD: threshold_q = cfg_data_i[PadW-1:0];
          CFG_POINTS_IN_USE:   points_q    = cfg_data_i[PtsW-1:0];
          default: ;
        endcase
      end
      if (req_i.valid && req_i.ready) begin
        if (req_i.action == ACT_LOAD) begin
          if (int'(req_i.point_index) < MaxPoints) begin
            bp_measured[req_i.point_index] = req_i.point_measured;
            bp_true[req_i.point_index]     = req_i.point_real;
          end
        end else begin
          pending_readings.push_back(predict_reading(req_i.proximity, req_i.pad_a,
                                                     req_i.pad_b, req_i.pad_c));
        end
      end
      if (res_i.valid && res_i.ready) begin
        got = '{res_i.valid_res, res_i.pressed, res_i.angle, res_i.minute};
        if (pending_readings.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("unexpected result: valid_res=%0d pressed=%0d angle=%0d minute=%0d",
                     got.valid_res, got.pressed, got.angle, got.minute);
        end else begin
          want = pending_readings.pop_front();
          if (got.valid_res !== want.valid_res || got.pressed !== want.pressed ||
              got.angle !== want.angle || got.minute !== want.minute) begin
            mismatches++;
            if (mismatches <= MaxReports)
              $display("mismatch: expected valid_res=%0d pressed=%0d angle=%0d minute=%0d,%s",
                       want.valid_res, want.pressed, want.angle, want.minute,
                       $sformatf(" got valid_res=%0d pressed=%0d angle=%0d minute=%0d",
                                 got.valid_res, got.pressed, got.angle, got.minute));
          end
        end
      end
    end
    fail_count_o  <= mismatches;
    outstanding_o <= pending_readings.size();
  end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the touch wheel block with breakpoint loads and wheel measurements
// under random idling and back-pressure, steps the registers through several
// settings between phases, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import twam_pkg::*;

  localparam int unsigned Phases      = 10;
  localparam int unsigned PhaseItems  = 70;
  localparam int unsigned TailCycles  = 100;   // beyond the longest measure latency
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned IdlePercent = 11;

  typedef struct packed {
    action_e         action;
    logic [PadW-1:0] proximity;
    logic [PadW-1:0] pad_a;
    logic [PadW-1:0] pad_b;
    logic [PadW-1:0] pad_c;
    logic [3:0]      slot;
    logic [AngW-1:0] meas_deg;
    logic [AngW-1:0] true_deg;
  } wheel_req_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  int unsigned         fail_count;
  int unsigned         outstanding;

  // Shared knobs between the request side and the result side
  bit                  calm;             // no idling on either side
  int unsigned         holdoff_asked;
  int unsigned         holdoff_served;
  logic [PadW-1:0]     thr_now;          // threshold last written, to aim proximity at

  twam_in_if  req_if ();
  twam_out_if res_if ();

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  touch_wheel_angle_to_minute dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (req_if),
    .out_o      (res_if)
  );

  twam_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .req_i         (req_if),
    .res_i         (res_if),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  // --------------------------------------------------------------------------
  // Result side: take results, idle at random, and serve long hold-offs when
  // the stimulus asks for one.
  // --------------------------------------------------------------------------
  initial begin : result_drain
    int unsigned held;
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (holdoff_asked != holdoff_served) begin
        // Block the output long enough for the block to back up its input
        holdoff_served++;
        res_if.ready <= 1'b0;
        for (held = 0; held < HoldCycles; held++) @(posedge clk_i);
      end
      res_if.ready <= calm || ($urandom_range(99) >= IdlePercent);
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Offer one request and hold it until taken. Valid stays high on return so
  // that back-to-back requests never drop it within a time step.
  task automatic offer(input wheel_req_t r);
    while (!calm && $urandom_range(99) < IdlePercent) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid          <= 1'b1;
    req_if.action         <= r.action;
    req_if.proximity      <= r.proximity;
    req_if.pad_a          <= r.pad_a;
    req_if.pad_b          <= r.pad_b;
    req_if.pad_c          <= r.pad_c;
    req_if.point_index    <= r.slot;
    req_if.point_measured <= r.meas_deg;
    req_if.point_real     <= r.true_deg;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  task automatic measure(input logic [PadW-1:0] prox, input logic [PadW-1:0] a,
                         input logic [PadW-1:0] b, input logic [PadW-1:0] c);
    wheel_req_t r;
    r           = '0;
    r.action    = ACT_MEASURE;
    r.proximity = prox;
    r.pad_a     = a;
    r.pad_b     = b;
    r.pad_c     = c;
    // Junk in the load fields: a measure must ignore them
    r.slot      = 4'($urandom);
    r.meas_deg  = AngW'($urandom);
    r.true_deg  = AngW'($urandom);
    offer(r);
  endtask

  task automatic load(input int unsigned slot, input int unsigned m, input int unsigned t);
    wheel_req_t r;
    r           = '0;
    r.action    = ACT_LOAD;
    r.slot      = 4'(slot);
    r.meas_deg  = AngW'(m);
    r.true_deg  = AngW'(t);
    // Junk in the measure fields: a load must ignore them
    r.proximity = PadW'($urandom);
    r.pad_a     = PadW'($urandom);
    r.pad_b     = PadW'($urandom);
    r.pad_c     = PadW'($urandom);
    offer(r);
  endtask

  // Drop valid, wait until every expected result has come, then let the
  // pipeline drain a little longer before anything is reconfigured.
  task automatic settle();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  // Write all three registers on consecutive edges while the block is idle.
  task automatic configure(input int unsigned off, input int unsigned thr,
                           input int unsigned pts);
    settle();
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_ANGLE_OFFSET;
    cfg_data <= CfgDataW'(off);
    @(posedge clk_i);
    cfg_idx  <= CFG_TOUCH_THRESHOLD;
    cfg_data <= CfgDataW'(thr);
    @(posedge clk_i);
    cfg_idx  <= CFG_POINTS_IN_USE;
    cfg_data <= CfgDataW'(pts);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    thr_now   = PadW'(thr);
  endtask

  // Load a full, strictly increasing table with true angles near the
  // measured ones, clipped to the legal range.
  task automatic load_smooth_table();
    int m, t, k;
    m = $urandom_range(0, 20);
    for (k = 0; k < MaxPoints; k++) begin
      t = m + int'($urandom_range(0, 30)) - 15;
      if (t < 0) t = 0;
      if (t > 360) t = 360;
      load(k, m, t);
      m += $urandom_range(1, 22);
    end
  endtask

  // Random measurement, shaped so that ties, zeros and extremes turn up often.
  task automatic measure_random();
    logic [PadW-1:0] a, b, c, prox;
    int unsigned     shape;
    a     = PadW'($urandom);
    b     = PadW'($urandom);
    c     = PadW'($urandom);
    shape = $urandom_range(0, 5);
    case (shape)
      1: begin
        a = PadW'($urandom_range(0, 7));
        b = PadW'($urandom_range(0, 7));
        c = PadW'($urandom_range(0, 7));
      end
      2: begin
        case ($urandom_range(0, 2))
          0:       b = a;
          1:       c = a;
          default: c = b;
        endcase
      end
      3: begin
        if ($urandom_range(1)) a = '0;
        if ($urandom_range(1)) b = '0;
        if ($urandom_range(1)) c = '0;
      end
      4: begin
        a = $urandom_range(1) ? '1 : PadW'($urandom_range(0, 1));
        b = $urandom_range(1) ? '1 : PadW'($urandom_range(0, 1));
        c = $urandom_range(1) ? PadW'(16'hFFFE) : PadW'($urandom_range(0, 1));
      end
      5: begin
        b = a + PadW'($urandom_range(0, 3));
        c = a + PadW'($urandom_range(0, 3));
      end
      default: ;
    endcase
    // Aim the proximity at the threshold edge now and then
    case ($urandom_range(0, 3))
      0:       prox = thr_now;
      1:       prox = thr_now + 1'b1;
      2:       prox = $urandom_range(1) ? '1 : '0;
      default: prox = PadW'($urandom);
    endcase
    measure(prox, a, b, c);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus and verdict
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned ph, n, pick, off, thr;
    calm           = 1'b0;
    holdoff_asked  = 0;
    holdoff_served = 0;
    thr_now        = '0;
    rst_ni                <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_idx               <= CFG_ANGLE_OFFSET;
    cfg_data              <= '0;
    req_if.valid          <= 1'b0;
    req_if.action         <= ACT_MEASURE;
    req_if.proximity      <= '0;
    req_if.pad_a          <= '0;
    req_if.pad_b          <= '0;
    req_if.pad_c          <= '0;
    req_if.point_index    <= '0;
    req_if.point_measured <= '0;
    req_if.point_real     <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, reset settings: two breakpoints spanning nearly the
    // whole turn, so low angles go negative and high ones run past 360.
    load(0, 10, 0);
    load(1, 350, 360);
    measure('0, '0, '0, '0);                     // no pad: not valid
    measure('1, '1, '0, '0);                     // pad a alone, below first point
    measure(16'd1, '0, 16'd1, '0);               // pad b alone, just pressed
    measure('0, '0, '0, '1);                     // pad c alone
    measure(16'd7, '1, '1, '1);                  // all equal: first difference zero
    measure(16'd9, 16'd100, 16'd500, 16'd100);   // a and c tied below b
    measure(16'd3, 16'd500, 16'd500, 16'd100);   // halfway in the first sector
    measure(16'd2, 16'd1000, 16'd1, '0);         // one zero pad, strong a
    measure('1, '1, '1, 16'hFFFE);               // near-full counts
    measure(16'd5, 16'd50, 16'd50, 16'd200);     // second difference zero
    measure(16'd4, 16'd300, 16'd100, 16'd100);   // first difference zero, wraps to 0
    measure(16'd6, 16'd23, '0, 16'd1);           // above the last point: saturate

    // Largest offset, unreachable threshold, points below the minimum, and a
    // segment of zero measured width.
    configure(359, 16'hFFFF, 1);
    load(0, 100, 200);
    load(1, 100, 50);
    measure('1, '1, '0, '0);
    measure('1, '0, 16'd1, '0);
    measure('1, '0, '0, '0);

    // Random part, one register setting per phase
    for (ph = 0; ph < Phases; ph++) begin
      off = $urandom_range(0, 359);
      thr = $urandom_range(1) ? $urandom_range(0, 255) : (32'($urandom) & 32'hFFFF);
      case (ph)
        0:       configure(0, 0, MaxPoints);
        1:       configure(359, 16'hFFFF, 2);
        2:       configure(off, thr, 31);            // above the maximum
        3:       configure(off, thr, 0);             // below the minimum
        default: configure(off, thr, $urandom_range(2, MaxPoints));
      endcase
      calm = (ph == 5);
      if (ph == 0) load_smooth_table();
      // Block the result side while requests keep coming
      if (ph == 3 || ph == 7) holdoff_asked++;
      for (n = 0; n < PhaseItems; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) load_smooth_table();
        else if (pick < 10) load($urandom_range(0, MaxPoints - 1), $urandom_range(0, 359),
                                 $urandom_range(0, 360));
        else measure_random();
      end
    end
    calm = 1'b0;

    settle();
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: many times the slowest legal run
  initial begin : watchdog
    #1_500_000;
    $display("tb: failure");
    $finish;
  end

endmodule

### touch_wheel_angle_to_minute.f
hw/rtl/twam_pkg.sv
hw/rtl/twam_in_if.sv
hw/rtl/twam_out_if.sv
hw/rtl/twam_ram.sv
hw/rtl/twam_div.sv
hw/rtl/touch_wheel_angle_to_minute.sv
sim/twam_checker.sv
sim/tb_top.sv
